// ===== rtl/tmf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_pkg
// Types, codes and constants shared by the TLV message filter.
// ----------------------------------------------------------------------------
package tmf_pkg;

  // payload bytes allowed per object
  localparam logic [8:0] OUT_LIMIT = 9'd255;

  localparam logic [7:0] PREFIX_B0 = 8'hFB;
  localparam logic [7:0] PREFIX_B1 = 8'h10;

  localparam logic [7:0] RST_DEST_TAG    = 8'd1;
  localparam logic [7:0] RST_TTL_TAG     = 8'd2;
  localparam logic [7:0] RST_DATA_TAG    = 8'd3;
  localparam logic [7:0] RST_DEFAULT_TTL = 8'd3;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEST_TAG    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TTL_TAG     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_TAG    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_TTL = 2'd3;

  typedef enum logic [2:0] {
    PH_TAG = 3'b001,
    PH_LEN = 3'b010,
    PH_VAL = 3'b100
  } phase_t;

  typedef enum logic [1:0] {
    EK_OTHER = 2'd0,
    EK_DEST  = 2'd1,
    EK_TTL   = 2'd2,
    EK_DATA  = 2'd3
  } elem_kind_t;

  typedef enum logic [1:0] {
    PF_UNDECIDED = 2'd0,
    PF_ACCEPT    = 2'd1,
    PF_REJECT    = 2'd2
  } prefix_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TRUNC    = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] dest_tag;
    logic [7:0] ttl_tag;
    logic [7:0] data_tag;
    logic [7:0] default_ttl;
    logic       ttl_load;
  } cfg_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic [7:0] ttl_value;
    logic [7:0] out_length;
    status_t    status;
    logic       last_of_run;
  } result_t;

  localparam int unsigned GRP_SLOTS = 3;

  typedef struct packed {
    logic                    load;
    logic [1:0]              count;
    result_t [GRP_SLOTS-1:0] slot;
  } group_t;

endpackage

// ===== rtl/tmf_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_in_if
// Input byte channel of the TLV message filter.
// ----------------------------------------------------------------------------
interface tmf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_object;

  modport source (output valid, output in_byte, output end_of_object, input ready);
  modport sink   (input valid, input in_byte, input end_of_object, output ready);
endinterface

// ===== rtl/tmf_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_out_if
// Result channel of the TLV message filter.
// ----------------------------------------------------------------------------
interface tmf_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] out_byte;
  logic [7:0] ttl_value;
  logic [7:0] out_length;
  logic [1:0] status;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output ttl_value,
                  output out_length, output status, output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input ttl_value,
                  input out_length, input status, input last_of_run, output ready);
endinterface

// ===== rtl/tmf_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_cfg_regs
// Tag registers with a plain write port; strobe for a default TTL write.
// ----------------------------------------------------------------------------
module tmf_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output tmf_pkg::cfg_t                 cfg
);

  logic [7:0] dest_tag_r;
  logic [7:0] ttl_tag_r;
  logic [7:0] data_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_tag_r <= tmf_pkg::RST_DEST_TAG;
      ttl_tag_r  <= tmf_pkg::RST_TTL_TAG;
      data_tag_r <= tmf_pkg::RST_DATA_TAG;
    end else if (cfg_we) begin
      case (cfg_index)
        tmf_pkg::CFG_DEST_TAG: dest_tag_r <= cfg_data;
        tmf_pkg::CFG_TTL_TAG:  ttl_tag_r  <= cfg_data;
        tmf_pkg::CFG_DATA_TAG: data_tag_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.dest_tag    = dest_tag_r;
  assign cfg.ttl_tag     = ttl_tag_r;
  assign cfg.data_tag    = data_tag_r;
  // write data, taken only together with ttl_load
  assign cfg.default_ttl = cfg_data;
  assign cfg.ttl_load    = cfg_we && (cfg_index == tmf_pkg::CFG_DEFAULT_TTL);

endmodule

// ===== rtl/tmf_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_parser
// Input register and per-byte TLV state update; builds the result group.
// ----------------------------------------------------------------------------
module tmf_parser (
  input  logic            clk,
  input  logic            rst_n,
  tmf_in_if.sink          in_ch,
  input  tmf_pkg::cfg_t   cfg,
  input  logic [7:0]      default_ttl,
  input  logic            grp_free,
  output tmf_pkg::group_t grp
);

  logic       in_v_r;
  logic [7:0] byte_r;
  logic       eoo_r;
  logic       process;

  tmf_pkg::phase_t     phase_r, phase_nxt;
  tmf_pkg::elem_kind_t ek_r, ek_nxt;
  tmf_pkg::prefix_t    pf_r, pf_nxt;
  logic [7:0]          bl_r, bl_nxt;
  logic [1:0]          vi_r, vi_nxt;
  logic [7:0]          ttl_r, ttl_nxt;
  logic [7:0]          cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;

  logic [1:0]      want_n;
  logic [1:0]      pay_n;
  logic [7:0]      w0;
  logic [7:0]      w1;
  logic [7:0]      bl_dec;
  logic [8:0]      room;
  tmf_pkg::result_t sum_res;
  tmf_pkg::result_t pay0_res;
  tmf_pkg::result_t pay1_res;
  logic [1:0]      n_res;

  assign process     = in_v_r && grp_free;
  assign in_ch.ready = !in_v_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_v_r <= 1'b1;
    end else if (process) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      byte_r <= in_ch.in_byte;
      eoo_r  <= in_ch.end_of_object;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    ek_nxt    = ek_r;
    pf_nxt    = pf_r;
    bl_nxt    = bl_r;
    vi_nxt    = vi_r;
    ttl_nxt   = ttl_r;
    want_n    = 2'd0;
    w0        = byte_r;
    w1        = tmf_pkg::PREFIX_B1;
    bl_dec    = bl_r - 8'd1;
    case (phase_r)
      tmf_pkg::PH_TAG: begin
        if (byte_r == cfg.dest_tag) begin
          ek_nxt = tmf_pkg::EK_DEST;
        end else if (byte_r == cfg.ttl_tag) begin
          ek_nxt = tmf_pkg::EK_TTL;
        end else if (byte_r == cfg.data_tag) begin
          ek_nxt = tmf_pkg::EK_DATA;
        end else begin
          ek_nxt = tmf_pkg::EK_OTHER;
        end
        phase_nxt = tmf_pkg::PH_LEN;
      end
      tmf_pkg::PH_LEN: begin
        bl_nxt    = byte_r;
        vi_nxt    = 2'd0;
        pf_nxt    = tmf_pkg::PF_UNDECIDED;
        phase_nxt = (byte_r == 8'd0) ? tmf_pkg::PH_TAG : tmf_pkg::PH_VAL;
      end
      tmf_pkg::PH_VAL: begin
        case (ek_r)
          tmf_pkg::EK_DEST: begin
            want_n = 2'd1;
          end
          tmf_pkg::EK_TTL: begin
            if (vi_r == 2'd0) ttl_nxt = byte_r;
          end
          tmf_pkg::EK_DATA: begin
            if (vi_r == 2'd0) begin
              pf_nxt = (byte_r == tmf_pkg::PREFIX_B0) ? tmf_pkg::PF_UNDECIDED
                                                      : tmf_pkg::PF_REJECT;
            end else if (vi_r == 2'd1) begin
              if (pf_r == tmf_pkg::PF_UNDECIDED && byte_r == tmf_pkg::PREFIX_B1) begin
                pf_nxt = tmf_pkg::PF_ACCEPT;
                want_n = 2'd2;
                w0     = tmf_pkg::PREFIX_B0;
              end else begin
                pf_nxt = tmf_pkg::PF_REJECT;
              end
            end else if (pf_r == tmf_pkg::PF_ACCEPT) begin
              want_n = 2'd1;
            end
          end
          default: ;
        endcase
        if (vi_r < 2'd2) vi_nxt = vi_r + 2'd1;
        bl_nxt = bl_dec;
        if (bl_dec == 8'd0) phase_nxt = tmf_pkg::PH_TAG;
      end
      default: ;
    endcase

    // output limit
    room    = tmf_pkg::OUT_LIMIT - {1'b0, cnt_r};
    ovf_nxt = ovf_r;
    if ({7'd0, want_n} > room) begin
      pay_n   = room[1:0];
      ovf_nxt = 1'b1;
    end else begin
      pay_n = want_n;
    end
    cnt_nxt = cnt_r + {6'd0, pay_n};

    sum_res.kind        = tmf_pkg::RK_SUMMARY;
    sum_res.out_byte    = 8'd0;
    sum_res.ttl_value   = ttl_nxt;
    sum_res.out_length  = cnt_nxt;
    sum_res.last_of_run = 1'b0;
    if (phase_nxt != tmf_pkg::PH_TAG) begin
      sum_res.status = tmf_pkg::ST_TRUNC;
    end else if (ovf_nxt) begin
      sum_res.status = tmf_pkg::ST_OVERFLOW;
    end else begin
      sum_res.status = tmf_pkg::ST_OK;
    end

    pay0_res             = '0;
    pay0_res.kind        = tmf_pkg::RK_PAYLOAD;
    pay0_res.out_byte    = w0;
    pay0_res.status      = tmf_pkg::ST_OK;
    pay1_res             = pay0_res;
    pay1_res.out_byte    = w1;

    n_res = pay_n + {1'b0, eoo_r};

    grp.load    = process;
    grp.count   = n_res;
    grp.slot[0] = (pay_n >= 2'd1) ? pay0_res : sum_res;
    grp.slot[1] = (pay_n >= 2'd2) ? pay1_res : sum_res;
    grp.slot[2] = sum_res;
    grp.slot[0].last_of_run = (n_res == 2'd1);
    grp.slot[1].last_of_run = (n_res == 2'd2);
    grp.slot[2].last_of_run = (n_res == 2'd3);

    if (eoo_r) begin
      phase_nxt = tmf_pkg::PH_TAG;
      ek_nxt    = tmf_pkg::EK_OTHER;
      bl_nxt    = 8'd0;
      vi_nxt    = 2'd0;
      pf_nxt    = tmf_pkg::PF_UNDECIDED;
      ttl_nxt   = default_ttl;
      cnt_nxt   = 8'd0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= tmf_pkg::PH_TAG;
      ek_r    <= tmf_pkg::EK_OTHER;
      pf_r    <= tmf_pkg::PF_UNDECIDED;
      bl_r    <= 8'd0;
      vi_r    <= 2'd0;
      ttl_r   <= tmf_pkg::RST_DEFAULT_TTL;
      cnt_r   <= 8'd0;
      ovf_r   <= 1'b0;
    end else begin
      if (process) begin
        phase_r <= phase_nxt;
        ek_r    <= ek_nxt;
        pf_r    <= pf_nxt;
        bl_r    <= bl_nxt;
        vi_r    <= vi_nxt;
        cnt_r   <= cnt_nxt;
        ovf_r   <= ovf_nxt;
      end
      if (cfg.ttl_load) begin
        ttl_r <= cfg.default_ttl;
      end else if (process) begin
        ttl_r <= ttl_nxt;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cnt_r} <= tmf_pkg::OUT_LIMIT)
    else $error("payload count past limit");

  a_eoo_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (process && eoo_r) |=> (phase_r == tmf_pkg::PH_TAG && cnt_r == 8'd0 && !ovf_r))
    else $error("object state not restarted after end of object");
`endif

endmodule

// ===== rtl/tmf_emitter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmf_emitter
// Result group register; sends its results one transfer at a time.
// ----------------------------------------------------------------------------
module tmf_emitter (
  input  logic            clk,
  input  logic            rst_n,
  input  tmf_pkg::group_t grp,
  output logic            grp_free,
  tmf_out_if.source       out_ch
);

  logic                                      valid_r;
  logic [1:0]                                ptr_r;
  logic [1:0]                                cnt_r;
  tmf_pkg::result_t [tmf_pkg::GRP_SLOTS-1:0] slot_r;
  tmf_pkg::result_t                          cur;
  logic                                      last;
  logic                                      xfer;

  assign cur      = slot_r[ptr_r];
  assign last     = (ptr_r == cnt_r - 2'd1);
  assign xfer     = valid_r && out_ch.ready;
  assign grp_free = !valid_r || (out_ch.ready && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= 2'd0;
      cnt_r   <= 2'd0;
    end else if (grp.load && grp.count != 2'd0) begin
      valid_r <= 1'b1;
      ptr_r   <= 2'd0;
      cnt_r   <= grp.count;
    end else if (xfer) begin
      if (last) begin
        valid_r <= 1'b0;
      end else begin
        ptr_r <= ptr_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (grp.load && grp.count != 2'd0) begin
      slot_r <= grp.slot;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.kind        = cur.kind;
  assign out_ch.out_byte    = cur.out_byte;
  assign out_ch.ttl_value   = cur.ttl_value;
  assign out_ch.out_length  = cur.out_length;
  assign out_ch.status      = cur.status;
  assign out_ch.last_of_run = cur.last_of_run;

`ifndef NO_ASSERTIONS
  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (ptr_r < cnt_r))
    else $error("result pointer past group count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    grp.load |-> grp_free)
    else $error("group loaded over pending results");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (cur.last_of_run == last))
    else $error("last_of_run does not match group end");
`endif

endmodule

// ===== rtl/tlv_message_filter_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_message_filter_top
// TLV message filter: forwards destination and prefixed data values,
// captures TTL and closes each object with a summary.
// ----------------------------------------------------------------------------
// in_ch carries one byte of the message object per transfer, with
// end_of_object on its final byte. out_ch carries one result per transfer:
// payload bytes (kind 0) and the end-of-object summary (kind 1), with
// last_of_run on the final result caused by an input byte.
// cfg_we/cfg_index/cfg_data write the tag registers and default TTL; write
// only while no byte is in flight.
// A transferred byte is held in the input register; its results are built
// from it combinationally and loaded into the result group register.
// Throughput: one byte per cycle while each byte gives at most one result
// and out_ch is ready; a byte that gives k results holds the single output
// register for k transfers, and bytes with no result do not load it.
// Reset: registers return to dest 1, ttl 2, data 3, default ttl 3; the
// parser expects a tag and the input and result registers are empty.
// Stall: the result group holds; one more byte is taken into the input
// register, after which in_ch.ready drops until the group drains.
// ----------------------------------------------------------------------------
module tlv_message_filter_top (
  input  logic                          clk,
  input  logic                          rst_n,
  tmf_in_if.sink                        in_ch,
  tmf_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [tmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data
);

  tmf_pkg::cfg_t   cfg;
  tmf_pkg::group_t grp;
  logic            grp_free;
  logic [7:0]      default_ttl_r;

  tmf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // restart value for ttl at each end of object
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_ttl_r <= tmf_pkg::RST_DEFAULT_TTL;
    end else if (cfg.ttl_load) begin
      default_ttl_r <= cfg.default_ttl;
    end
  end

  tmf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .cfg         (cfg),
    .default_ttl (default_ttl_r),
    .grp_free    (grp_free),
    .grp         (grp)
  );

  tmf_emitter u_emitter (
    .clk      (clk),
    .rst_n    (rst_n),
    .grp      (grp),
    .grp_free (grp_free),
    .out_ch   (out_ch)
  );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the TLV message filter. A driver feeds message bytes from a
// queue and a model of the filter predicts the payload and summary results
// of each accepted byte. A monitor compares every result transfer field by
// field. The run steps through several tag settings with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int VAL_RANDOM    = 0;
  localparam int VAL_PREFIXED  = 1;
  localparam int VAL_NEAR_MISS = 2;
  localparam int HOLD_CYCLES   = 200;

  typedef struct packed {
    logic [7:0] b;
    logic       eoo;
  } msg_byte_t;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tmf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [7:0]                    cfg_data;

  tmf_in_if  in_ch ();
  tmf_out_if out_ch ();

  tlv_message_filter_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // register copies
  logic [7:0] r_dest        = tmf_pkg::RST_DEST_TAG;
  logic [7:0] r_ttl         = tmf_pkg::RST_TTL_TAG;
  logic [7:0] r_data        = tmf_pkg::RST_DATA_TAG;
  logic [7:0] r_default_ttl = tmf_pkg::RST_DEFAULT_TTL;

  // parser state of the filter model
  tmf_pkg::phase_t     ps_phase    = tmf_pkg::PH_TAG;
  tmf_pkg::elem_kind_t ps_kind     = tmf_pkg::EK_OTHER;
  logic [7:0]          ps_left     = '0;
  logic [1:0]          ps_index    = '0;
  tmf_pkg::prefix_t    ps_prefix   = tmf_pkg::PF_UNDECIDED;
  logic [7:0]          ps_ttl      = tmf_pkg::RST_DEFAULT_TTL;
  logic [7:0]          ps_count    = '0;
  logic                ps_overflow = 1'b0;

  tmf_pkg::result_t burst [0:2];
  int               burst_len;

  msg_byte_t        byte_stream [$];
  tmf_pkg::result_t filter_outputs [$];
  logic [7:0]       obj_bytes [$];
  msg_byte_t        cur_byte;
  tmf_pkg::result_t want;

  int unsigned send_idle_pct = 30;
  int unsigned recv_idle_pct = 84;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  int unsigned error_count     = 0;
  int unsigned bytes_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned objects_queued  = 0;
  int unsigned bytes_queued    = 0;
  int unsigned reg_writes      = 0;

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.in_byte     = '0;
    in_ch.end_of_object = 1'b0;
    out_ch.ready      = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic tmf_pkg::result_t make_result(input logic kind, input logic [7:0] b,
                                                   input logic [7:0] ttl,
                                                   input logic [7:0] len,
                                                   input tmf_pkg::status_t st);
    tmf_pkg::result_t r;
    r.kind        = kind;
    r.out_byte    = b;
    r.ttl_value   = ttl;
    r.out_length  = len;
    r.status      = st;
    r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic emit_payload(input logic [7:0] b);
    if ({1'b0, ps_count} < tmf_pkg::OUT_LIMIT) begin
      burst[burst_len] = make_result(tmf_pkg::RK_PAYLOAD, b, 8'd0, 8'd0, tmf_pkg::ST_OK);
      burst_len++;
      ps_count++;
    end else begin
      ps_overflow = 1'b1;
    end
  endtask

  // filter model: one accepted byte in, its results appended to filter_outputs
  task automatic filter_byte(input logic [7:0] b, input logic eoo);
    tmf_pkg::status_t st;
    burst_len = 0;
    case (ps_phase)
      tmf_pkg::PH_TAG: begin
        if (b == r_dest) ps_kind = tmf_pkg::EK_DEST;
        else if (b == r_ttl) ps_kind = tmf_pkg::EK_TTL;
        else if (b == r_data) ps_kind = tmf_pkg::EK_DATA;
        else ps_kind = tmf_pkg::EK_OTHER;
        ps_phase = tmf_pkg::PH_LEN;
      end
      tmf_pkg::PH_LEN: begin
        ps_left   = b;
        ps_index  = '0;
        ps_prefix = tmf_pkg::PF_UNDECIDED;
        ps_phase  = (b == 8'd0) ? tmf_pkg::PH_TAG : tmf_pkg::PH_VAL;
      end
      default: begin
        case (ps_kind)
          tmf_pkg::EK_DEST: emit_payload(b);
          tmf_pkg::EK_TTL: begin
            if (ps_index == 2'd0) ps_ttl = b;
          end
          tmf_pkg::EK_DATA: begin
            if (ps_index == 2'd0) begin
              ps_prefix = (b == tmf_pkg::PREFIX_B0) ? tmf_pkg::PF_UNDECIDED
                                                    : tmf_pkg::PF_REJECT;
            end else if (ps_index == 2'd1) begin
              if (ps_prefix == tmf_pkg::PF_UNDECIDED && b == tmf_pkg::PREFIX_B1) begin
                ps_prefix = tmf_pkg::PF_ACCEPT;
                emit_payload(tmf_pkg::PREFIX_B0);
                emit_payload(tmf_pkg::PREFIX_B1);
              end else begin
                ps_prefix = tmf_pkg::PF_REJECT;
              end
            end else if (ps_prefix == tmf_pkg::PF_ACCEPT) begin
              emit_payload(b);
            end
          end
          default: ;
        endcase
        if (ps_index < 2'd2) ps_index++;
        ps_left--;
        if (ps_left == 8'd0) ps_phase = tmf_pkg::PH_TAG;
      end
    endcase
    if (eoo) begin
      st = tmf_pkg::ST_OK;
      if (ps_phase != tmf_pkg::PH_TAG) st = tmf_pkg::ST_TRUNC;
      else if (ps_overflow) st = tmf_pkg::ST_OVERFLOW;
      burst[burst_len] = make_result(tmf_pkg::RK_SUMMARY, 8'd0, ps_ttl, ps_count, st);
      burst_len++;
      ps_phase    = tmf_pkg::PH_TAG;
      ps_kind     = tmf_pkg::EK_OTHER;
      ps_left     = '0;
      ps_index    = '0;
      ps_prefix   = tmf_pkg::PF_UNDECIDED;
      ps_ttl      = r_default_ttl;
      ps_count    = '0;
      ps_overflow = 1'b0;
    end
    if (burst_len > 0) burst[burst_len-1].last_of_run = 1'b1;
    for (int i = 0; i < burst_len; i++) filter_outputs.push_back(burst[i]);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        filter_byte(cur_byte.b, cur_byte.eoo);
        bytes_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_stream.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_byte = byte_stream.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.in_byte       <= cur_byte.b;
          in_ch.end_of_object <= cur_byte.eoo;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_checked++;
        if (filter_outputs.size() == 0) begin
          $error("unexpected result transfer: kind %0d byte %0d", out_ch.kind,
                 out_ch.out_byte);
          error_count++;
        end else begin
          want = filter_outputs.pop_front();
          check_field("kind", want.kind, out_ch.kind);
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("ttl_value", want.ttl_value, out_ch.ttl_value);
          check_field("out_length", want.out_length, out_ch.out_length);
          check_field("status", want.status, out_ch.status);
          check_field("last_of_run", want.last_of_run, out_ch.last_of_run);
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES - 1;
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic write_reg(input logic [tmf_pkg::CFG_IDX_W-1:0] idx, input logic [7:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      tmf_pkg::CFG_DEST_TAG: r_dest = v;
      tmf_pkg::CFG_TTL_TAG:  r_ttl  = v;
      tmf_pkg::CFG_DATA_TAG: r_data = v;
      default: begin
        r_default_ttl = v;
        ps_ttl        = v;
      end
    endcase
  endtask

  task automatic wait_quiet();
    while (byte_stream.size() != 0 || in_ch.valid || filter_outputs.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic flush_object(input bit close_it);
    for (int i = 0; i < obj_bytes.size(); i++)
      byte_stream.push_back('{b: obj_bytes[i], eoo: close_it && (i == obj_bytes.size() - 1)});
    bytes_queued += obj_bytes.size();
    if (close_it) objects_queued++;
    obj_bytes.delete();
  endtask

  task automatic add_elem(input logic [7:0] tag, input int len, input int style);
    obj_bytes.push_back(tag);
    obj_bytes.push_back(len[7:0]);
    for (int i = 0; i < len; i++) begin
      if (style != VAL_RANDOM && i == 0) obj_bytes.push_back(tmf_pkg::PREFIX_B0);
      else if (style == VAL_PREFIXED && i == 1) obj_bytes.push_back(tmf_pkg::PREFIX_B1);
      else if (style == VAL_NEAR_MISS && i == 1)
        obj_bytes.push_back(tmf_pkg::PREFIX_B1 ^ (8'd1 << $urandom_range(7)));
      else obj_bytes.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic gen_object();
    int n_elem;
    int len;
    int cut;
    if ($urandom_range(6) == 0) begin
      // noise
      repeat ($urandom_range(6, 1)) obj_bytes.push_back(8'($urandom_range(255)));
    end else begin
      n_elem = $urandom_range(4, 1);
      repeat (n_elem) begin
        len = ($urandom_range(7) == 0) ? $urandom_range(12) : $urandom_range(4);
        case ($urandom_range(9))
          0, 1:    add_elem(r_dest, len, VAL_RANDOM);
          2:       add_elem(r_ttl, len, VAL_RANDOM);
          3, 4, 5: add_elem(r_data, ($urandom_range(5) == 0) ? $urandom_range(1) : len + 2,
                            VAL_PREFIXED);
          6:       add_elem(r_data, len, VAL_NEAR_MISS);
          7:       add_elem(r_data, len, VAL_RANDOM);
          default: add_elem(8'($urandom_range(255)), len, VAL_RANDOM);
        endcase
      end
      // truncated object
      if ($urandom_range(5) == 0) begin
        cut = $urandom_range(obj_bytes.size(), 1);
        while (obj_bytes.size() > cut) void'(obj_bytes.pop_back());
      end
    end
    flush_object(1'b1);
  endtask

  task automatic gen_objects(input int unsigned count);
    int unsigned stop_at;
    stop_at = bytes_queued + count;
    while (bytes_queued < stop_at) gen_object();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset tags: every element kind, short and empty elements, repeated ttl
    obj_bytes = '{tmf_pkg::RST_TTL_TAG, 8'd1, 8'h40,
                  tmf_pkg::RST_DEST_TAG, 8'd2, 8'h00, 8'hFF,
                  tmf_pkg::RST_DATA_TAG, 8'd3, tmf_pkg::PREFIX_B0, tmf_pkg::PREFIX_B1, 8'hAA,
                  tmf_pkg::RST_DATA_TAG, 8'd1, tmf_pkg::PREFIX_B0,
                  tmf_pkg::RST_TTL_TAG, 8'd0,
                  tmf_pkg::RST_TTL_TAG, 8'd1, 8'h21, 8'h09, 8'd0};
    flush_object(1'b1);
    // object ends right after a tag
    obj_bytes = '{tmf_pkg::RST_DATA_TAG};
    flush_object(1'b1);
    // default ttl write lands in the middle of an object
    obj_bytes = '{tmf_pkg::RST_TTL_TAG, 8'd1, 8'h55, tmf_pkg::RST_DEST_TAG};
    flush_object(1'b0);
    wait_quiet();
    write_reg(tmf_pkg::CFG_DEFAULT_TTL, 8'hFF);
    @(negedge clk);
    obj_bytes = '{8'd1, 8'h77};
    flush_object(1'b1);
    gen_objects(60);
    wait_quiet();

    write_reg(tmf_pkg::CFG_DEST_TAG, 8'h00);
    write_reg(tmf_pkg::CFG_TTL_TAG, 8'hFF);
    write_reg(tmf_pkg::CFG_DATA_TAG, 8'h80);
    write_reg(tmf_pkg::CFG_DEFAULT_TTL, 8'h00);
    @(negedge clk);
    gen_objects(60);
    wait_quiet();

    // dest and ttl share a tag
    send_idle_pct = 84;
    recv_idle_pct = 30;
    write_reg(tmf_pkg::CFG_DEST_TAG, 8'h05);
    write_reg(tmf_pkg::CFG_TTL_TAG, 8'h05);
    write_reg(tmf_pkg::CFG_DATA_TAG, 8'h09);
    write_reg(tmf_pkg::CFG_DEFAULT_TTL, 8'hC8);
    @(negedge clk);
    gen_objects(25);
    wait_quiet();
    // ttl and data share a tag
    write_reg(tmf_pkg::CFG_TTL_TAG, 8'h09);
    @(negedge clk);
    gen_objects(25);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(tmf_pkg::CFG_DEST_TAG, 8'hFF);
    write_reg(tmf_pkg::CFG_TTL_TAG, 8'h00);
    write_reg(tmf_pkg::CFG_DATA_TAG, tmf_pkg::PREFIX_B0);
    write_reg(tmf_pkg::CFG_DEFAULT_TTL, 8'h80);
    @(negedge clk);
    hold_req = 1'b1;
    gen_objects(60);
    // output limit reached with only the first prefix byte fitting
    add_elem(r_dest, 200, VAL_RANDOM);
    add_elem(r_dest, 54, VAL_RANDOM);
    add_elem(r_data, 3, VAL_PREFIXED);
    flush_object(1'b1);
    // overflow followed by truncation
    add_elem(r_dest, 255, VAL_RANDOM);
    add_elem(r_dest, 10, VAL_RANDOM);
    repeat (5) void'(obj_bytes.pop_back());
    flush_object(1'b1);
    gen_objects(10);
    wait_quiet();

    $display("covered %0d objects, %0d bytes in, %0d results checked, %0d register writes",
             objects_queued, bytes_sent, results_checked, reg_writes);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
